// ----- design/kruskal_spanning_tree_length_defines.svh -----
// Assertion helpers shared by the top module and the root finder.
// Both expect signals named clk and rst in the module that uses them.
`ifndef KRUSKAL_SPANNING_TREE_LENGTH_DEFINES_SVH
`define KRUSKAL_SPANNING_TREE_LENGTH_DEFINES_SVH

// Same-cycle implication.
`define KST_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/kst_pkg.sv -----
`timescale 1ns / 1ps

package kst_pkg;

  localparam int KST_MAX_VERTICES = 1024;
  localparam int KST_EP_W  = 10;  // endpoint field width
  localparam int KST_WT_W  = 24;  // edge weight width
  localparam int KST_LEN_W = 32;  // running total width
  localparam int KST_NC_W  = 11;  // node_count register width

  localparam logic [KST_NC_W-1:0] KST_NC_RESET = 11'd1024;

  // status of the root finder, seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } kst_find_stat_t;

endpackage

// ----- design/kruskal_spanning_tree_length.sv -----
`timescale 1ns / 1ps
`include "kruskal_spanning_tree_length_defines.svh"
// Channel  Handshake            Payload
// in       in_valid / in_ready  new_tree, endpoint_a, endpoint_b, edge_weight
// out      out_valid/out_ready  accepted, tree_length, tree_done
// cfg      cfg_write            cfg_data (node_count)
//
// After reset every parent store entry is set to identity; in_ready is low meanwhile.
// An item with new_tree set runs the same identity pass before its edge.
// An edge runs a root walk for each endpoint, each after one modulo step per MAX_VERTICES
// above that endpoint; once the tree is complete the edge skips both. The root walks
// share one finder on one memory read port.
// A finished item waits in the output register; the next item is taken meanwhile.

module kruskal_spanning_tree_length import kst_pkg::*; #(
  parameter int MAX_VERTICES = KST_MAX_VERTICES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 new_tree,
  input  logic [KST_EP_W-1:0]  endpoint_a,
  input  logic [KST_EP_W-1:0]  endpoint_b,
  input  logic [KST_WT_W-1:0]  edge_weight,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 accepted,
  output logic [KST_LEN_W-1:0] tree_length,
  output logic                 tree_done,
  input  logic                 cfg_write,
  input  logic [KST_NC_W-1:0]  cfg_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = (VW + 1 > KST_NC_W) ? VW + 1 : KST_NC_W;
  localparam logic [NW-1:0] NC_MIN = NW'(2);
  localparam logic [NW-1:0] NC_MAX = NW'(MAX_VERTICES);
  localparam logic [VW-1:0] LAST   = VW'(MAX_VERTICES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_FINDA = 3'd3;
  localparam logic [2:0] S_GOB   = 3'd4;
  localparam logic [2:0] S_FINDB = 3'd5;
  localparam logic [2:0] S_LINK  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]           state;
  logic [VW-1:0]        swp;
  logic                 clr_item;
  logic [KST_NC_W-1:0]  node_count;
  logic [VW-1:0]        count;
  logic [KST_LEN_W-1:0] total;
  logic                 took;
  logic [KST_EP_W-1:0]  ea;
  logic [KST_EP_W-1:0]  eb;
  logic [KST_WT_W-1:0]  wt;
  logic [VW-1:0]        ra;
  logic [VW-1:0]        rb;

  logic [NW-1:0]        nc_ext;
  logic [NW-1:0]        nc_clamp;
  logic [VW-1:0]        target;
  logic [KST_LEN_W:0]   sum;
  logic [KST_LEN_W-1:0] total_sat;

  logic                 mem_we;
  logic [VW-1:0]        mem_waddr;
  logic [VW-1:0]        mem_wdata;
  logic                 rd_en;
  logic [VW-1:0]        rd_addr;
  logic [VW-1:0]        rd_data;
  logic                 find_start;
  logic [KST_EP_W-1:0]  find_vtx;
  logic [VW-1:0]        find_root;
  kst_find_stat_t       find_stat;

  assign nc_ext   = NW'(node_count);
  assign nc_clamp = (nc_ext < NC_MIN) ? NC_MIN : ((nc_ext > NC_MAX) ? NC_MAX : nc_ext);
  assign target   = VW'(nc_clamp - NW'(1));

  assign sum       = {1'b0, total} + (KST_LEN_W + 1)'(wt);
  assign total_sat = sum[KST_LEN_W] ? '1 : sum[KST_LEN_W-1:0];

  assign in_ready = (state == S_IDLE);

  assign find_start = ((state == S_CHECK) && (count < target)) || (state == S_GOB);
  assign find_vtx   = (state == S_GOB) ? eb : ea;

  assign mem_we    = (state == S_CLEAR) || ((state == S_LINK) && (ra != rb));
  assign mem_waddr = (state == S_CLEAR) ? swp : ra;
  assign mem_wdata = (state == S_CLEAR) ? swp : rb;

  kst_parent_mem #(.MAX_VERTICES(MAX_VERTICES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  kst_find #(.MAX_VERTICES(MAX_VERTICES)) u_find (
    .clk     (clk),
    .rst     (rst),
    .start   (find_start),
    .vtx     (find_vtx),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .root    (find_root),
    .stat    (find_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= KST_NC_RESET;
    end else if (cfg_write) begin
      node_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      swp      <= '0;
      clr_item <= 1'b0;
      count    <= '0;
      total    <= '0;
      took     <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          swp <= swp + VW'(1);
          if (swp == LAST) begin
            swp      <= '0;
            clr_item <= 1'b0;
            state    <= clr_item ? S_CHECK : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            ea <= endpoint_a;
            eb <= endpoint_b;
            wt <= edge_weight;
            if (new_tree) begin
              count    <= '0;
              total    <= '0;
              clr_item <= 1'b1;
              state    <= S_CLEAR;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          // complete tree: edge ignored
          if (count >= target) begin
            took  <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_FINDA;
          end
        end
        S_FINDA: begin
          if (find_stat.done) begin
            ra    <= find_root;
            state <= S_GOB;
          end
        end
        S_GOB: begin
          state <= S_FINDB;
        end
        S_FINDB: begin
          if (find_stat.done) begin
            rb    <= find_root;
            state <= S_LINK;
          end
        end
        S_LINK: begin
          took <= (ra != rb);
          if (ra != rb) begin
            total <= total_sat;
            count <= count + VW'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      accepted    <= took;
      tree_length <= total;
      tree_done   <= (count >= target);
    end
  end

  `KST_ASSERT_NEXT(a_total_mono, state == S_LINK, total >= $past(total), "total decreased")
  `KST_ASSERT_NEXT(a_count_step, state == S_LINK, count - $past(count) <= VW'(1), "count jumped")
  `KST_ASSERT_IMPL(a_took_target, (state == S_OUT) && took, count <= target, "edge taken past target")
  `KST_ASSERT_IMPL(a_find_free, find_start, !find_stat.busy, "finder started while busy")

endmodule

// ----- design/kst_parent_mem.sv -----
`timescale 1ns / 1ps

module kst_parent_mem import kst_pkg::*; #(
  parameter int MAX_VERTICES = KST_MAX_VERTICES,
  localparam int VW = $clog2(MAX_VERTICES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [VW-1:0] waddr,
  input  logic [VW-1:0] wdata,
  input  logic          re,
  input  logic [VW-1:0] raddr,
  output logic [VW-1:0] rdata
);

  logic [VW-1:0] mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/kst_find.sv -----
`timescale 1ns / 1ps
`include "kruskal_spanning_tree_length_defines.svh"

module kst_find import kst_pkg::*; #(
  parameter int MAX_VERTICES = KST_MAX_VERTICES,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int RW = (VW + 1 > KST_EP_W) ? VW + 1 : KST_EP_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KST_EP_W-1:0] vtx,
  output logic                rd_en,
  output logic [VW-1:0]       rd_addr,
  input  logic [VW-1:0]       rd_data,
  output logic [VW-1:0]       root,
  output kst_find_stat_t      stat
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MOD  = 2'd1;
  localparam logic [1:0] F_WALK = 2'd2;

  localparam logic [RW-1:0] MAXR = RW'(MAX_VERTICES);

  logic [1:0]    fstate;
  logic [RW-1:0] r;
  logic [VW-1:0] v;

  // one hop per cycle: the registered read data addresses the next read
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = r[VW-1:0];
    if (fstate == F_MOD && r < MAXR) begin
      rd_en = 1'b1;
    end
    if (fstate == F_WALK && rd_data != v) begin
      rd_en   = 1'b1;
      rd_addr = rd_data;
    end
  end

  assign root      = v;
  assign stat.busy = (fstate != F_IDLE);
  assign stat.done = (fstate == F_WALK) && (rd_data == v);

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      case (fstate)
        F_IDLE: begin
          if (start) begin
            r      <= RW'(vtx);
            fstate <= F_MOD;
          end
        end
        F_MOD: begin
          // index modulo the store depth, one subtract per cycle
          if (r >= MAXR) begin
            r <= r - MAXR;
          end else begin
            v      <= r[VW-1:0];
            fstate <= F_WALK;
          end
        end
        F_WALK: begin
          if (rd_data == v) begin
            fstate <= F_IDLE;
          end else begin
            v <= rd_data;
          end
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

  `KST_ASSERT_IMPL(a_start_idle, start, fstate == F_IDLE, "find started while busy")
  `KST_ASSERT_IMPL(a_rd_range, rd_en, RW'(rd_addr) < MAXR, "parent read out of range")
  `KST_ASSERT_NEXT(a_done_idle, stat.done, fstate == F_IDLE, "finder busy after root found")

endmodule
